FILE: design/sst_pkg.sv
// Shared types and constants for the four-sensor sun tracker.
`default_nettype none

package sst_pkg;

    localparam int unsigned ANGLE_BITS    = 8;
    localparam int unsigned THR_BITS      = 7;
    localparam int unsigned QBITS         = 7;
    localparam int unsigned NUM_CH        = 4;
    localparam int unsigned CH_BITS       = 2;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 8;

    localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(NUM_CH - 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANGLE_STEP     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DEGREES    = 2'd2;

    localparam logic [THR_BITS-1:0]   THR_RESET  = 7'd5;
    localparam logic [ANGLE_BITS-1:0] STEP_RESET = 8'd2;
    localparam logic [ANGLE_BITS-1:0] MAXD_RESET = 8'd180;
    localparam logic [ANGLE_BITS-1:0] POS_RESET  = 8'd90;

    localparam logic [QBITS-1:0] NORM_FULL = 7'd100;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] pos;
        logic                  moved;
    } axis_result_t;

endpackage

`default_nettype wire

FILE: design/sst_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module sst_div
    import sst_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 10
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [SAMPLE_BITS+QBITS-1:0] numerator,
    input  wire logic [SAMPLE_BITS-1:0]       denominator,
    output logic      [QBITS-1:0]             quotient,
    output div_status_t                       status
);

    localparam int unsigned NW = SAMPLE_BITS + QBITS;

    logic [NW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    dsh_reg, dsh_next;
    logic [QBITS-1:0] q_reg, q_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ge;

    assign ge = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numerator;
            dsh_next  = NW'({1'b0, denominator, {(QBITS-1){1'b0}}});
            cnt_next  = 3'(QBITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            q_next   = {q_reg[QBITS-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

FILE: design/sst_axis.sv
// Threshold test, step and clamp of one servo axis.
`default_nettype none

module sst_axis
    import sst_pkg::*;
(
    input  wire logic        [ANGLE_BITS-1:0] pos,
    input  wire logic signed [8:0]            diff,
    input  wire logic        [THR_BITS-1:0]   threshold,
    input  wire logic        [ANGLE_BITS-1:0] step,
    input  wire logic        [ANGLE_BITS-1:0] max_deg,
    output axis_result_t                      result
);

    logic signed [8:0]  mag;
    logic signed [9:0]  sum;
    logic [ANGLE_BITS-1:0] clamped;
    logic               moved;

    always_comb
    begin
        mag   = (diff < 0) ? -diff : diff;
        moved = $unsigned(mag) > {2'b00, threshold};
        if (diff > 0)
        begin
            sum = $signed({2'b00, pos}) - $signed({2'b00, step});
        end
        else
        begin
            sum = $signed({2'b00, pos}) + $signed({2'b00, step});
        end
        if (sum < 0)
        begin
            clamped = '0;
        end
        else if (sum > $signed({2'b00, max_deg}))
        begin
            clamped = max_deg;
        end
        else
        begin
            clamped = sum[ANGLE_BITS-1:0];
        end
        result.moved = moved;
        result.pos   = moved ? clamped : pos;
    end

endmodule

`default_nettype wire

FILE: design/four_sensor_sun_tracker_core.sv
// Top level of the four-sensor sun tracker with its sequencer and state.
// A calibration item passes from S_IDLE to S_MOVE, which raises out_valid with its result. A tracking
// item walks the channels in S_LOAD: a channel that needs no division is settled there, and one
// that uses the shared divider waits in S_DIV; then S_MOVE raises out_valid. in_stall is high until
// the sequencer is back in S_IDLE, and a stalled result holds the next one until taken.
// Reset sets the marks to empty, both angles to 90 and the registers to defaults.
`default_nettype none

module four_sensor_sun_tracker_core
    import sst_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 10
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     kind,
    input  wire logic [SAMPLE_BITS-1:0]   sample_top_left,
    input  wire logic [SAMPLE_BITS-1:0]   sample_top_right,
    input  wire logic [SAMPLE_BITS-1:0]   sample_bottom_left,
    input  wire logic [SAMPLE_BITS-1:0]   sample_bottom_right,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [ANGLE_BITS-1:0]         pan_angle,
    output logic [ANGLE_BITS-1:0]         tilt_angle,
    output logic                          pan_moved,
    output logic                          tilt_moved,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int unsigned NW = SAMPLE_BITS + QBITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_MOVE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CH_BITS-1:0]     ch_reg, ch_next;
    logic                   kind_reg, kind_next;
    logic [SAMPLE_BITS-1:0] sample_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] sample_next [NUM_CH];
    logic [SAMPLE_BITS-1:0] low_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] low_next [NUM_CH];
    logic [SAMPLE_BITS-1:0] high_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] high_next [NUM_CH];
    logic [QBITS-1:0]       norm_reg [NUM_CH];
    logic [QBITS-1:0]       norm_next [NUM_CH];
    logic [THR_BITS-1:0]    thr_reg, thr_next;
    logic [ANGLE_BITS-1:0]  step_reg, step_next;
    logic [ANGLE_BITS-1:0]  maxd_reg, maxd_next;
    logic [ANGLE_BITS-1:0]  pan_pos_reg, pan_pos_next;
    logic [ANGLE_BITS-1:0]  tilt_pos_reg, tilt_pos_next;
    logic                   pan_moved_reg, pan_moved_next;
    logic                   tilt_moved_reg, tilt_moved_next;
    logic                   out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0] in_sample [NUM_CH];
    logic [SAMPLE_BITS-1:0] cur_s, cur_lo, cur_hi;
    logic                   in_accept;
    logic                   load_out;
    logic                   pan_move, tilt_move;
    logic                   div_start;
    logic [NW-1:0]          div_num;
    logic [SAMPLE_BITS-1:0] div_den;
    logic [QBITS-1:0]       div_q;
    div_status_t            div_st;

    logic [QBITS:0]         sum_top, sum_bottom, sum_left, sum_right;
    logic signed [8:0]      pan_diff, tilt_diff;
    axis_result_t           pan_res, tilt_res;

    assign in_sample[0] = sample_top_left;
    assign in_sample[1] = sample_top_right;
    assign in_sample[2] = sample_bottom_left;
    assign in_sample[3] = sample_bottom_right;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign load_out  = (state_reg == S_MOVE) && (!out_valid_reg || !out_stall);

    assign cur_s   = sample_reg[ch_reg];
    assign cur_lo  = low_reg[ch_reg];
    assign cur_hi  = high_reg[ch_reg];
    assign div_num = NW'(cur_s - cur_lo) * NW'(NORM_FULL);
    assign div_den = cur_hi - cur_lo;

    // Channel order: top left, top right, bottom left, bottom right.
    assign sum_top    = {1'b0, norm_reg[0]} + {1'b0, norm_reg[1]};
    assign sum_right  = {1'b0, norm_reg[1]} + {1'b0, norm_reg[3]};
    assign sum_bottom = {1'b0, norm_reg[3]} + {1'b0, norm_reg[2]};
    assign sum_left   = {1'b0, norm_reg[0]} + {1'b0, norm_reg[2]};
    assign pan_diff   = $signed({2'b00, sum_left[QBITS:1]})
                      - $signed({2'b00, sum_right[QBITS:1]});
    assign tilt_diff  = $signed({2'b00, sum_top[QBITS:1]})
                      - $signed({2'b00, sum_bottom[QBITS:1]});

    assign pan_move  = kind_reg && pan_res.moved;
    assign tilt_move = kind_reg && tilt_res.moved;

    sst_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .numerator   (div_num),
        .denominator (div_den),
        .quotient    (div_q),
        .status      (div_st)
    );

    sst_axis u_pan (
        .pos       (pan_pos_reg),
        .diff      (pan_diff),
        .threshold (thr_reg),
        .step      (step_reg),
        .max_deg   (maxd_reg),
        .result    (pan_res)
    );

    sst_axis u_tilt (
        .pos       (tilt_pos_reg),
        .diff      (tilt_diff),
        .threshold (thr_reg),
        .step      (step_reg),
        .max_deg   (maxd_reg),
        .result    (tilt_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        kind_next       = kind_reg;
        sample_next     = sample_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        norm_next       = norm_reg;
        thr_next        = thr_reg;
        step_next       = step_reg;
        maxd_next       = maxd_reg;
        pan_pos_next    = pan_pos_reg;
        tilt_pos_next   = tilt_pos_reg;
        pan_moved_next  = pan_moved_reg;
        tilt_moved_next = tilt_moved_reg;
        out_valid_next  = out_valid_reg && out_stall;
        div_start       = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOVE_THRESHOLD: thr_next  = cfg_data[THR_BITS-1:0];
                CFG_ANGLE_STEP:     step_next = cfg_data[ANGLE_BITS-1:0];
                CFG_MAX_DEGREES:    maxd_next = cfg_data[ANGLE_BITS-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next   = kind;
                    sample_next = in_sample;
                    ch_next     = '0;
                    if (kind)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_CH; i++)
                        begin
                            if (in_sample[i] < low_reg[i])
                            begin
                                low_next[i] = in_sample[i];
                            end
                            if (in_sample[i] > high_reg[i])
                            begin
                                high_next[i] = in_sample[i];
                            end
                        end
                        state_next = S_MOVE;
                    end
                end
            end
            S_LOAD:
            begin
                if ((cur_hi <= cur_lo) || (cur_s <= cur_lo) || (cur_s >= cur_hi))
                begin
                    norm_next[ch_reg] = ((cur_hi > cur_lo) && (cur_s >= cur_hi))
                                        ? NORM_FULL : '0;
                    ch_next = ch_reg + 1'b1;
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_MOVE;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    norm_next[ch_reg] = div_q;
                    ch_next = ch_reg + 1'b1;
                    state_next = (ch_reg == CH_LAST) ? S_MOVE : S_LOAD;
                end
            end
            S_MOVE:
            begin
                if (load_out)
                begin
                    if (kind_reg)
                    begin
                        pan_pos_next  = pan_res.pos;
                        tilt_pos_next = tilt_res.pos;
                    end
                    pan_moved_next  = pan_move;
                    tilt_moved_next = tilt_move;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ch_reg         <= '0;
            kind_reg       <= 1'b0;
            thr_reg        <= THR_RESET;
            step_reg       <= STEP_RESET;
            maxd_reg       <= MAXD_RESET;
            pan_pos_reg    <= POS_RESET;
            tilt_pos_reg   <= POS_RESET;
            pan_moved_reg  <= 1'b0;
            tilt_moved_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                low_reg[i]  <= '1;
                high_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ch_reg         <= ch_next;
            kind_reg       <= kind_next;
            thr_reg        <= thr_next;
            step_reg       <= step_next;
            maxd_reg       <= maxd_next;
            pan_pos_reg    <= pan_pos_next;
            tilt_pos_reg   <= tilt_pos_next;
            pan_moved_reg  <= pan_moved_next;
            tilt_moved_reg <= tilt_moved_next;
            out_valid_reg  <= out_valid_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        norm_reg   <= norm_next;
    end

    assign out_valid  = out_valid_reg;
    assign pan_angle  = pan_pos_reg;
    assign tilt_angle = tilt_pos_reg;
    assign pan_moved  = pan_moved_reg;
    assign tilt_moved = tilt_moved_reg;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("Divider started while still busy.");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIV))
        else $error("Divider finished outside the divide state.");

    a_pan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !pan_move) |=> (pan_pos_reg == $past(pan_pos_reg)))
        else $error("Pan angle changed without a move.");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MOVE) && kind_reg) |->
            ((norm_reg[0] <= NORM_FULL) && (norm_reg[1] <= NORM_FULL)
             && (norm_reg[2] <= NORM_FULL) && (norm_reg[3] <= NORM_FULL)))
        else $error("Normalized sample above full scale.");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/four_sensor_sun_tracker_checker.sv
// Scoreboard for the four-sensor sun tracker: predicts each item's angles and compares results.
module four_sensor_sun_tracker_checker
    import sst_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 10
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic                     kind,
    input  wire logic [SAMPLE_BITS-1:0]   sample_top_left,
    input  wire logic [SAMPLE_BITS-1:0]   sample_top_right,
    input  wire logic [SAMPLE_BITS-1:0]   sample_bottom_left,
    input  wire logic [SAMPLE_BITS-1:0]   sample_bottom_right,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic [ANGLE_BITS-1:0]    pan_angle,
    input  wire logic [ANGLE_BITS-1:0]    tilt_angle,
    input  wire logic                     pan_moved,
    input  wire logic                     tilt_moved,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                            fail_count,
    output int                            pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_CAL = 1'b0;
    localparam int   CH_TL    = 0;
    localparam int   CH_TR    = 1;
    localparam int   CH_BL    = 2;
    localparam int   CH_BR    = 3;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] pan;
        logic [ANGLE_BITS-1:0] tilt;
        logic                  pan_moved;
        logic                  tilt_moved;
    } aim_t;

    logic [THR_BITS-1:0]    thr;
    logic [ANGLE_BITS-1:0]  step_deg;
    logic [ANGLE_BITS-1:0]  max_deg;
    logic [SAMPLE_BITS-1:0] low_mark [NUM_CH];
    logic [SAMPLE_BITS-1:0] high_mark [NUM_CH];
    logic [ANGLE_BITS-1:0]  pan_pos;
    logic [ANGLE_BITS-1:0]  tilt_pos;
    aim_t                   aim_q [$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    function automatic int level_pct(input int s, input int lo, input int hi);
        if (hi <= lo || s <= lo)
        begin
            return 0;
        end
        if (s >= hi)
        begin
            return int'(NORM_FULL);
        end
        return ((s - lo) * int'(NORM_FULL)) / (hi - lo);
    endfunction

    function automatic logic [ANGLE_BITS-1:0] step_axis(input logic [ANGLE_BITS-1:0] pos,
                                                        input int diff, output logic moved);
        int mag;
        int p;
        mag = (diff < 0) ? -diff : diff;
        p = int'(pos);
        moved = 1'b0;
        if (mag > int'(thr))
        begin
            moved = 1'b1;
            p = (diff > 0) ? p - int'(step_deg) : p + int'(step_deg);
            if (p < 0)
            begin
                p = 0;
            end
            if (p > int'(max_deg))
            begin
                p = int'(max_deg);
            end
        end
        return p[ANGLE_BITS-1:0];
    endfunction

    task automatic predict_aim();
        int   s [NUM_CH];
        int   lvl [NUM_CH];
        int   top_avg;
        int   bottom_avg;
        int   left_avg;
        int   right_avg;
        logic pm;
        logic tm;
        aim_t want;
        s[CH_TL] = int'(sample_top_left);
        s[CH_TR] = int'(sample_top_right);
        s[CH_BL] = int'(sample_bottom_left);
        s[CH_BR] = int'(sample_bottom_right);
        pm = 1'b0;
        tm = 1'b0;
        if (kind == KIND_CAL)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                if (s[ch] < int'(low_mark[ch]))
                begin
                    low_mark[ch] = s[ch][SAMPLE_BITS-1:0];
                end
                if (s[ch] > int'(high_mark[ch]))
                begin
                    high_mark[ch] = s[ch][SAMPLE_BITS-1:0];
                end
            end
        end
        else
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                lvl[ch] = level_pct(s[ch], int'(low_mark[ch]), int'(high_mark[ch]));
            end
            top_avg    = (lvl[CH_TL] + lvl[CH_TR]) / 2;
            right_avg  = (lvl[CH_TR] + lvl[CH_BR]) / 2;
            bottom_avg = (lvl[CH_BR] + lvl[CH_BL]) / 2;
            left_avg   = (lvl[CH_TL] + lvl[CH_BL]) / 2;
            pan_pos  = step_axis(pan_pos, left_avg - right_avg, pm);
            tilt_pos = step_axis(tilt_pos, top_avg - bottom_avg, tm);
        end
        want.pan        = pan_pos;
        want.tilt       = tilt_pos;
        want.pan_moved  = pm;
        want.tilt_moved = tm;
        aim_q.push_back(want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        aim_t want;
        if (!rst_n)
        begin
            thr      = THR_RESET;
            step_deg = STEP_RESET;
            max_deg  = MAXD_RESET;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                low_mark[ch]  = '1;
                high_mark[ch] = '0;
            end
            pan_pos  = POS_RESET;
            tilt_pos = POS_RESET;
            aim_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (aim_q.size() == 0)
                begin
                    report_mismatch("result arrived with no item outstanding");
                end
                else
                begin
                    want = aim_q.pop_front();
                    if (pan_angle !== want.pan)
                    begin
                        report_mismatch($sformatf("pan_angle got %0d, want %0d",
                                                  pan_angle, want.pan));
                    end
                    if (tilt_angle !== want.tilt)
                    begin
                        report_mismatch($sformatf("tilt_angle got %0d, want %0d",
                                                  tilt_angle, want.tilt));
                    end
                    if (pan_moved !== want.pan_moved)
                    begin
                        report_mismatch($sformatf("pan_moved got %0b, want %0b",
                                                  pan_moved, want.pan_moved));
                    end
                    if (tilt_moved !== want.tilt_moved)
                    begin
                        report_mismatch($sformatf("tilt_moved got %0b, want %0b",
                                                  tilt_moved, want.tilt_moved));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_aim();
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MOVE_THRESHOLD: thr      = cfg_data[THR_BITS-1:0];
                    CFG_ANGLE_STEP:     step_deg = cfg_data[ANGLE_BITS-1:0];
                    CFG_MAX_DEGREES:    max_deg  = cfg_data[ANGLE_BITS-1:0];
                    default: ;
                endcase
            end
        end
        pending_results = aim_q.size();
    end

endmodule

FILE: tb/sv/four_sensor_sun_tracker_core_tb.sv
// Testbench top for the four-sensor sun tracker: drives items, settings and stalls.
module four_sensor_sun_tracker_core_tb
    import sst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   SAMPLE_BITS  = 10;
    localparam int   SMAX         = (1 << SAMPLE_BITS) - 1;
    localparam logic KIND_CAL     = 1'b0;
    localparam logic KIND_TRACK   = 1'b1;
    localparam int   PHASES       = 8;
    localparam int   PHASE_ITEMS  = 118;
    localparam int   QUIET_LIMIT  = 2000;
    localparam int   DRAIN_CYCLES = 40;

    localparam int THR_TAB [PHASES]  = '{5, 0, 100, 10, 3, 20, 1, 50};
    localparam int STEP_TAB [PHASES] = '{2, 255, 7, 9, 0, 13, 40, 1};
    localparam int MAXD_TAB [PHASES] = '{180, 255, 200, 1, 120, 0, 255, 90};

    logic                     clk;
    logic                     rst_n               = 1'b0;
    logic                     in_valid            = 1'b0;
    logic                     kind                = 1'b0;
    logic [SAMPLE_BITS-1:0]   sample_top_left     = '0;
    logic [SAMPLE_BITS-1:0]   sample_top_right    = '0;
    logic [SAMPLE_BITS-1:0]   sample_bottom_left  = '0;
    logic [SAMPLE_BITS-1:0]   sample_bottom_right = '0;
    logic                     out_stall           = 1'b0;
    logic                     cfg_we              = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index           = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data            = '0;
    wire logic                in_stall;
    wire logic                out_valid;
    wire logic [ANGLE_BITS-1:0] pan_angle;
    wire logic [ANGLE_BITS-1:0] tilt_angle;
    wire logic                pan_moved;
    wire logic                tilt_moved;

    int fail_count;
    int pending_results;
    int send_pct    = 0;
    int recv_pct    = 0;
    int cal_items   = 0;
    int track_items = 0;
    int quiet_cycles = 0;

    four_sensor_sun_tracker_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .kind                (kind),
        .sample_top_left     (sample_top_left),
        .sample_top_right    (sample_top_right),
        .sample_bottom_left  (sample_bottom_left),
        .sample_bottom_right (sample_bottom_right),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .pan_angle           (pan_angle),
        .tilt_angle          (tilt_angle),
        .pan_moved           (pan_moved),
        .tilt_moved          (tilt_moved),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    four_sensor_sun_tracker_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .kind                (kind),
        .sample_top_left     (sample_top_left),
        .sample_top_right    (sample_top_right),
        .sample_bottom_left  (sample_bottom_left),
        .sample_bottom_right (sample_bottom_right),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .pan_angle           (pan_angle),
        .tilt_angle          (tilt_angle),
        .pan_moved           (pan_moved),
        .tilt_moved          (tilt_moved),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .fail_count          (fail_count),
        .pending_results     (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog expired: no handshake for %0d cycles.", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic k, input int tl, input int tr, input int bl,
                             input int br);
        logic taken;
        while (send_pct != 0 && $urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid            <= 1'b1;
        kind                <= k;
        sample_top_left     <= tl[SAMPLE_BITS-1:0];
        sample_top_right    <= tr[SAMPLE_BITS-1:0];
        sample_bottom_left  <= bl[SAMPLE_BITS-1:0];
        sample_bottom_right <= br[SAMPLE_BITS-1:0];
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        if (k == KIND_CAL)
        begin
            cal_items++;
        end
        else
        begin
            track_items++;
        end
    endtask

    task automatic random_item(input bit wide_cal);
        int s [4];
        int base;
        int spread;
        bit scatter;
        if ($urandom_range(99) < 20)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (wide_cal && $urandom_range(9) == 0)
                begin
                    s[i] = $urandom_range(SMAX);
                end
                else
                begin
                    s[i] = $urandom_range(820, 200);
                end
            end
            send_item(KIND_CAL, s[0], s[1], s[2], s[3]);
        end
        else
        begin
            base    = $urandom_range(870, 150);
            spread  = $urandom_range(300);
            scatter = 1'($urandom_range(1));
            for (int i = 0; i < 4; i++)
            begin
                if (scatter)
                begin
                    s[i] = $urandom_range(SMAX);
                end
                else
                begin
                    s[i] = base + int'($urandom_range(2 * spread)) - spread;
                    s[i] = (s[i] < 0) ? 0 : ((s[i] > SMAX) ? SMAX : s[i]);
                end
            end
            send_item(KIND_TRACK, s[0], s[1], s[2], s[3]);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic set_tracking(input int thr, input int step_deg, input int max_deg);
        write_reg(CFG_MOVE_THRESHOLD, thr);
        write_reg(CFG_ANGLE_STEP, step_deg);
        write_reg(CFG_MAX_DEGREES, max_deg);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items run under the reset settings.
        send_item(KIND_TRACK, 512, 512, 512, 512);
        send_item(KIND_TRACK, SMAX, 0, 0, 0);
        send_item(KIND_CAL, 300, 300, 300, 300);
        send_item(KIND_TRACK, SMAX, 0, 500, 300);
        send_item(KIND_CAL, 700, 700, 700, 700);
        send_item(KIND_TRACK, 0, 0, 0, 0);
        send_item(KIND_TRACK, SMAX, SMAX, SMAX, SMAX);
        send_item(KIND_TRACK, SMAX, 0, SMAX, 0);
        send_item(KIND_TRACK, 0, SMAX, 0, SMAX);
        send_item(KIND_TRACK, SMAX, SMAX, 0, 0);
        send_item(KIND_TRACK, 0, 0, SMAX, SMAX);
        send_item(KIND_TRACK, 340, 320, 340, 320);
        send_item(KIND_TRACK, 344, 320, 344, 320);
        send_item(KIND_TRACK, 500, 400, 450, 350);
        send_item(KIND_TRACK, SMAX, 0, 0, SMAX);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            set_tracking(THR_TAB[p], STEP_TAB[p], MAXD_TAB[p]);
            if (p < 3)
            begin
                send_pct = 27;
                recv_pct = 47;
            end
            else if (p < 6)
            begin
                send_pct = 47;
                recv_pct = 27;
            end
            else
            begin
                send_pct = 0;
                recv_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item(p >= 6);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d calibration and %0d tracking items under %0d register settings,",
                 cal_items, track_items, PHASES + 1);
        $display("with idle gaps on the sender, stalls on the receiver, and neither.");
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/sst_pkg.sv
design/sst_div.sv
design/sst_axis.sv
design/four_sensor_sun_tracker_core.sv
tb/sv/four_sensor_sun_tracker_checker.sv
tb/sv/four_sensor_sun_tracker_core_tb.sv
